[sv/dominant_page_format_select_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the dominant page format select unit
// Immediate-consequence and next-cycle property checks, removed for synthesis.
// ----------------------------------------------------------------------------
`ifndef DOMINANT_PAGE_FORMAT_SELECT_UNIT_MACROS_SVH
`define DOMINANT_PAGE_FORMAT_SELECT_UNIT_MACROS_SVH

`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define DPFS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("dpfs: same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define DPFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("dpfs: next-cycle check failed");
`else
`define DPFS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define DPFS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[sv/dpfs_pkg.sv]
// ----------------------------------------------------------------------------
// Dominant page format select package
// Shared constants, result codes and the controller/datapath handshake types.
// ----------------------------------------------------------------------------
package dpfs_pkg;

	// Default table geometry.
	localparam int MAX_FORMATS_DEF = 16;
	localparam int COUNT_BITS_DEF  = 20;

	// Field widths.
	localparam int SIZE_W   = 31;
	localparam int CHOSEN_W = 2;
	localparam int HALF_W   = 16;
	localparam int PLO_W    = HALF_W + SIZE_W;
	localparam int PHI_W    = (SIZE_W - HALF_W) + SIZE_W;
	localparam int AREA_W   = 2 * SIZE_W;
	localparam int RATIO_W  = SIZE_W + 6;

	// Ratio bounds as integer fractions over RATIO_DEN.
	localparam int RATIO_DEN    = 25;
	localparam int RATIO_LO_MIN = 14;
	localparam int RATIO_LO_MAX = 21;
	localparam int RATIO_HI_MIN = 28;
	localparam int RATIO_HI_MAX = 42;

	// Codes for how the slot size was chosen.
	localparam logic [CHOSEN_W-1:0] CHOSEN_FREQUENT     = 2'd0;
	localparam logic [CHOSEN_W-1:0] CHOSEN_PROPORTIONAL = 2'd1;
	localparam logic [CHOSEN_W-1:0] CHOSEN_FIRST        = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;
		logic idx_clr;
		logic idx_inc;
		logic rd_en;
		logic wr_hit;
		logic wr_new;
		logic ovf_set;
		logic sel_init;
		logic freq_chk;
		logic prop_lo;
		logic prop_hi;
		logic prop_cmp;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic page_valid;
		logic last;
		logic idx_end;
		logic hit;
		logic full;
		logic found;
		logic out_free;
	} stat_t;

endpackage

[sv/dpfs_stream_if.sv]
// ----------------------------------------------------------------------------
// Dominant page format select stream interfaces
// Valid/ready channels for page words in and slot words out.
// ----------------------------------------------------------------------------

// Page size channel.
interface dpfs_page_if;
	logic                         valid;
	logic                         ready;
	logic [dpfs_pkg::SIZE_W-1:0]  page_height;
	logic [dpfs_pkg::SIZE_W-1:0]  page_width;
	logic                         last_page;

	modport source(output valid, output page_height, output page_width,
		output last_page, input ready);
	modport sink(input valid, input page_height, input page_width,
		input last_page, output ready);
endinterface

// Chosen slot channel.
interface dpfs_slot_if;
	logic                           valid;
	logic                           ready;
	logic [dpfs_pkg::SIZE_W-1:0]    slot_height;
	logic [dpfs_pkg::SIZE_W-1:0]    slot_width;
	logic [dpfs_pkg::CHOSEN_W-1:0]  chosen_by;
	logic                           table_overflow;

	modport source(output valid, output slot_height, output slot_width,
		output chosen_by, output table_overflow, input ready);
	modport sink(input valid, input slot_height, input slot_width,
		input chosen_by, input table_overflow, output ready);
endinterface

[sv/dpfs_datapath.sv]
// ----------------------------------------------------------------------------
// Dominant page format select datapath
// Format table memory, match and selection registers, area multiplier and
// the registered slot word output.
// ----------------------------------------------------------------------------
`include "dominant_page_format_select_unit_macros.svh"

module dpfs_datapath #(
	parameter int MAX_FORMATS = dpfs_pkg::MAX_FORMATS_DEF,
	parameter int COUNT_BITS  = dpfs_pkg::COUNT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	dpfs_page_if.sink         page,
	dpfs_slot_if.source       slot,
	input  dpfs_pkg::cmd_t    cmd,
	output dpfs_pkg::stat_t   stat
);

	localparam int SW      = dpfs_pkg::SIZE_W;
	localparam int CNT_W   = $clog2(MAX_FORMATS + 1);
	localparam int IDX_W   = (MAX_FORMATS > 1) ? $clog2(MAX_FORMATS) : 1;
	localparam int ENTRY_W = 2 * SW + COUNT_BITS;

	// Page word held for the whole scan.
	logic [SW-1:0] h_q;
	logic [SW-1:0] w_q;
	logic          last_q;

	// Table control.
	logic [CNT_W-1:0] used_q;
	logic [CNT_W-1:0] idx_q;
	logic             ovf_q;

	// Table memory and its registered read word.
	logic [ENTRY_W-1:0] mem_q [MAX_FORMATS];
	logic [ENTRY_W-1:0] rd_q;
	logic               we;
	logic [IDX_W-1:0]   waddr;
	logic [ENTRY_W-1:0] wdata;

	logic [SW-1:0]         rd_h;
	logic [SW-1:0]         rd_w;
	logic [COUNT_BITS-1:0] rd_cnt;
	logic [COUNT_BITS-1:0] cnt_inc;

	// Selection state.
	logic [COUNT_BITS-1:0]            best_cnt_q;
	logic [dpfs_pkg::AREA_W-1:0]      best_area_q;
	logic [SW-1:0]                    pick_h_q;
	logic [SW-1:0]                    pick_w_q;
	logic [dpfs_pkg::CHOSEN_W-1:0]    how_q;
	logic                             found_q;

	// Proportion test and split area product.
	logic [dpfs_pkg::RATIO_W-1:0] h25;
	logic [dpfs_pkg::RATIO_W-1:0] w_lo_min;
	logic [dpfs_pkg::RATIO_W-1:0] w_lo_max;
	logic [dpfs_pkg::RATIO_W-1:0] w_hi_min;
	logic [dpfs_pkg::RATIO_W-1:0] w_hi_max;
	logic                         prop;
	logic                         prop_q;
	logic [dpfs_pkg::PLO_W-1:0]   prod_lo;
	logic [dpfs_pkg::PHI_W-1:0]   prod_hi;
	logic [dpfs_pkg::PLO_W-1:0]   prod_lo_q;
	logic [dpfs_pkg::PHI_W-1:0]   prod_hi_q;
	logic [dpfs_pkg::AREA_W-1:0]  area;

	// Output word register.
	logic                           out_valid_q;
	logic [SW-1:0]                  out_h_q;
	logic [SW-1:0]                  out_w_q;
	logic [dpfs_pkg::CHOSEN_W-1:0]  out_how_q;
	logic                           out_ovf_q;

	logic load_in;

	// Read word fields.
	assign rd_h    = rd_q[ENTRY_W-1 -: SW];
	assign rd_w    = rd_q[COUNT_BITS + SW - 1 -: SW];
	assign rd_cnt  = rd_q[COUNT_BITS-1:0];
	assign cnt_inc = (rd_cnt == '1) ? rd_cnt : rd_cnt + COUNT_BITS'(1);

	// Input handshake.
	assign page.ready = cmd.take;
	assign load_in    = cmd.take && page.valid;

	always_ff @(posedge clk) begin
		if (load_in) begin
			h_q    <= page.page_height;
			w_q    <= page.page_width;
			last_q <= page.last_page;
		end
	end

	// Table write port: a count update at the scan index or a new entry at the fill point.
	assign we    = cmd.wr_hit || cmd.wr_new;
	assign waddr = cmd.wr_new ? used_q[IDX_W-1:0] : idx_q[IDX_W-1:0];
	assign wdata = cmd.wr_new ? {h_q, w_q, COUNT_BITS'(1)} : {rd_h, rd_w, cnt_inc};

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (cmd.rd_en) begin
			rd_q <= mem_q[idx_q[IDX_W-1:0]];
		end
	end

	// Scan index, fill count and sticky overflow flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			used_q <= '0;
			ovf_q  <= 1'b0;
		end else begin
			if (cmd.idx_clr || cmd.sel_init) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (cmd.emit) begin
				used_q <= '0;
				ovf_q  <= 1'b0;
			end else begin
				if (cmd.wr_new) begin
					used_q <= used_q + CNT_W'(1);
				end
				if (cmd.ovf_set) begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	// Ratio window test by cross multiplication with small constants.
	assign h25      = dpfs_pkg::RATIO_W'(rd_h) * dpfs_pkg::RATIO_W'(dpfs_pkg::RATIO_DEN);
	assign w_lo_min = dpfs_pkg::RATIO_W'(rd_w) * dpfs_pkg::RATIO_W'(dpfs_pkg::RATIO_LO_MIN);
	assign w_lo_max = dpfs_pkg::RATIO_W'(rd_w) * dpfs_pkg::RATIO_W'(dpfs_pkg::RATIO_LO_MAX);
	assign w_hi_min = dpfs_pkg::RATIO_W'(rd_w) * dpfs_pkg::RATIO_W'(dpfs_pkg::RATIO_HI_MIN);
	assign w_hi_max = dpfs_pkg::RATIO_W'(rd_w) * dpfs_pkg::RATIO_W'(dpfs_pkg::RATIO_HI_MAX);
	assign prop     = ((h25 >= w_lo_min) && (h25 <= w_lo_max)) ||
		((h25 >= w_hi_min) && (h25 <= w_hi_max));

	// Area in two halves of the height, one partial product per cycle.
	assign prod_lo = rd_h[dpfs_pkg::HALF_W-1:0] * rd_w;
	assign prod_hi = rd_h[SW-1:dpfs_pkg::HALF_W] * rd_w;
	assign area    = dpfs_pkg::AREA_W'(prod_lo_q) + {prod_hi_q, dpfs_pkg::HALF_W'(0)};

	always_ff @(posedge clk) begin
		if (cmd.prop_lo) begin
			prop_q    <= prop;
			prod_lo_q <= prod_lo;
		end
		if (cmd.prop_hi) begin
			prod_hi_q <= prod_hi;
		end
	end

	// Selection: most frequent pass, then largest proportional pass.
	// Entry 0 is always captured so it stands as the fallback.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.sel_init) begin
			found_q <= 1'b0;
		end else if (cmd.freq_chk && (rd_cnt > best_cnt_q)) begin
			found_q <= 1'b1;
		end else if (cmd.prop_cmp && prop_q && (area > best_area_q)) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sel_init) begin
			best_cnt_q  <= COUNT_BITS'(1);
			best_area_q <= '0;
		end else if (cmd.freq_chk) begin
			if (rd_cnt > best_cnt_q) begin
				best_cnt_q <= rd_cnt;
				how_q      <= dpfs_pkg::CHOSEN_FREQUENT;
			end
			if ((rd_cnt > best_cnt_q) || (idx_q == '0)) begin
				pick_h_q <= rd_h;
				pick_w_q <= rd_w;
			end
		end else if (cmd.prop_cmp && prop_q && (area > best_area_q)) begin
			best_area_q <= area;
			how_q       <= dpfs_pkg::CHOSEN_PROPORTIONAL;
			pick_h_q    <= rd_h;
			pick_w_q    <= rd_w;
		end
	end

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (slot.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_h_q   <= pick_h_q;
			out_w_q   <= pick_w_q;
			out_how_q <= found_q ? how_q : dpfs_pkg::CHOSEN_FIRST;
			out_ovf_q <= ovf_q;
		end
	end

	assign slot.valid          = out_valid_q;
	assign slot.slot_height    = out_h_q;
	assign slot.slot_width     = out_w_q;
	assign slot.chosen_by      = out_how_q;
	assign slot.table_overflow = out_ovf_q;

	// Status to the controller.
	assign stat.page_valid = page.valid;
	assign stat.last       = last_q;
	assign stat.idx_end    = (idx_q == used_q);
	assign stat.hit        = (rd_h == h_q) && (rd_w == w_q);
	assign stat.full       = (used_q == CNT_W'(MAX_FORMATS));
	assign stat.found      = found_q;
	assign stat.out_free   = !out_valid_q || slot.ready;

	// Checks.
	`DPFS_ASSERT_IMPLIES(a_used_range, clk, arst_n, 1'b1, used_q <= CNT_W'(MAX_FORMATS))
	`DPFS_ASSERT_IMPLIES(a_no_append_full, clk, arst_n, cmd.wr_new, used_q < CNT_W'(MAX_FORMATS))
	`DPFS_ASSERT_NEXT(a_clear_after_emit, clk, arst_n, cmd.emit, (used_q == '0) && !ovf_q)

endmodule

[sv/dpfs_ctrl.sv]
// ----------------------------------------------------------------------------
// Dominant page format select controller
// Sequences the table match scan, the two selection passes and the result.
// ----------------------------------------------------------------------------
`include "dominant_page_format_select_unit_macros.svh"

module dpfs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  dpfs_pkg::stat_t  stat,
	output dpfs_pkg::cmd_t   cmd
);

	typedef enum logic [9:0] {
		ST_IDLE      = 10'b00_0000_0001,
		ST_MATCH_RD  = 10'b00_0000_0010,
		ST_MATCH_CHK = 10'b00_0000_0100,
		ST_FREQ_RD   = 10'b00_0000_1000,
		ST_FREQ_CHK  = 10'b00_0001_0000,
		ST_PROP_RD   = 10'b00_0010_0000,
		ST_PROP_LO   = 10'b00_0100_0000,
		ST_PROP_HI   = 10'b00_1000_0000,
		ST_PROP_CMP  = 10'b01_0000_0000,
		ST_EMIT      = 10'b10_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands.
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.take = 1'b1;
				if (stat.page_valid) begin
					cmd.idx_clr = 1'b1;
					state_d     = ST_MATCH_RD;
				end
			end
			ST_MATCH_RD: begin
				if (stat.idx_end) begin
					// No stored format matched: append or drop.
					if (stat.full) begin
						cmd.ovf_set = 1'b1;
					end else begin
						cmd.wr_new = 1'b1;
					end
					if (stat.last) begin
						cmd.sel_init = 1'b1;
						state_d      = ST_FREQ_RD;
					end else begin
						state_d = ST_IDLE;
					end
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = ST_MATCH_CHK;
				end
			end
			ST_MATCH_CHK: begin
				if (stat.hit) begin
					cmd.wr_hit = 1'b1;
					if (stat.last) begin
						cmd.sel_init = 1'b1;
						state_d      = ST_FREQ_RD;
					end else begin
						state_d = ST_IDLE;
					end
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = ST_MATCH_RD;
				end
			end
			ST_FREQ_RD: begin
				if (stat.idx_end) begin
					if (stat.found) begin
						state_d = ST_EMIT;
					end else begin
						cmd.idx_clr = 1'b1;
						state_d     = ST_PROP_RD;
					end
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = ST_FREQ_CHK;
				end
			end
			ST_FREQ_CHK: begin
				cmd.freq_chk = 1'b1;
				cmd.idx_inc  = 1'b1;
				state_d      = ST_FREQ_RD;
			end
			ST_PROP_RD: begin
				if (stat.idx_end) begin
					state_d = ST_EMIT;
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = ST_PROP_LO;
				end
			end
			ST_PROP_LO: begin
				cmd.prop_lo = 1'b1;
				state_d     = ST_PROP_HI;
			end
			ST_PROP_HI: begin
				cmd.prop_hi = 1'b1;
				state_d     = ST_PROP_CMP;
			end
			ST_PROP_CMP: begin
				cmd.prop_cmp = 1'b1;
				cmd.idx_inc  = 1'b1;
				state_d      = ST_PROP_RD;
			end
			ST_EMIT: begin
				// Wait for the output register to free up.
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Checks.
	`DPFS_ASSERT_IMPLIES(a_emit_free, clk, arst_n, cmd.emit, stat.out_free)
	`DPFS_ASSERT_IMPLIES(a_read_in_range, clk, arst_n, cmd.rd_en, !stat.idx_end)
	`DPFS_ASSERT_NEXT(a_idle_after_emit, clk, arst_n, cmd.emit, cmd.take)

endmodule

[sv/dominant_page_format_select_unit.sv]
// One page at a time: a page that is not the last is scanned against the stored
// entries until it matches one or, when it is new, is appended or dropped if full.
// A last page adds a frequency pass, a proportional pass when no format repeats,
// and the load of the slot word; that load waits while the previous slot word is
// unaccepted.
// Reset clears the fill count, the overflow flag, the controller and the output valid flag.
// ----------------------------------------------------------------------------
// Dominant page format select unit
// Counts distinct page formats and picks the slot size on the last page.
// ----------------------------------------------------------------------------
module dominant_page_format_select_unit #(
	parameter int MAX_FORMATS = dpfs_pkg::MAX_FORMATS_DEF,
	parameter int COUNT_BITS  = dpfs_pkg::COUNT_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	dpfs_page_if.sink     page,
	dpfs_slot_if.source   slot
);

	dpfs_pkg::cmd_t  cmd;
	dpfs_pkg::stat_t stat;

	// Sequencer.
	dpfs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	// Table, selection and output register.
	dpfs_datapath #(
		.MAX_FORMATS (MAX_FORMATS),
		.COUNT_BITS  (COUNT_BITS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.page   (page),
		.slot   (slot),
		.cmd    (cmd),
		.stat   (stat)
	);

endmodule
